FILE: sv/bcbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcbr_pkg
// shared constants, types and helpers for the circle and bar rasterizer
// ----------------------------------------------------------------------------
package bcbr_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 22;
  localparam int FRAME_SIZE     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(FRAME_SIZE);
  localparam int COL_W          = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W          = $clog2(SCREEN_ROWS);

  typedef enum logic [1:0] {
    FUNC_FILL   = 2'd0,
    FUNC_CIRCLE = 2'd1,
    FUNC_BAR    = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_READ0,
    ST_READ1,
    ST_DONE
  } state_t;

  // floor and ceil of a Q.4 value, wide signed
  function automatic logic signed [15:0] floor16(input logic signed [15:0] v);
    floor16 = v >>> 4;
  endfunction

  function automatic logic signed [15:0] ceil16(input logic signed [15:0] v);
    ceil16 = (v + 16'sd15) >>> 4;
  endfunction

endpackage : bcbr_pkg
`default_nettype wire

FILE: sv/bcbr_frame_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcbr_frame_mem
// one-bit frame store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bcbr_frame_mem
  import bcbr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic              wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic                   rdata
);

  logic mem [FRAME_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : bcbr_frame_mem
`default_nettype wire

FILE: sv/bitmap_circle_and_bar_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_circle_and_bar_rasterizer
// draws filled circles and bars into an 80x22 one-bit frame, reads glyphs
// ----------------------------------------------------------------------------
// One command at a time. After reset the frame store is cleared by a pass
// over every pixel during which no command is taken. Fill writes every pixel
// of the frame store, circle and bar scan their clipped bounding box (the
// whole frame store for a full-screen box), one pixel per cycle. The pixel
// test has one registered multiply stage, so a pixel decision passes the
// product registers and then the write-enable register before it reaches the
// store; pixels are only ever set, so no read is needed while drawing. The
// result beat is held in an output register until taken.
module bitmap_circle_and_bar_rasterizer
  import bcbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_bar_thickness,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic signed [11:0] in_point_a_x,
  input  wire logic signed [11:0] in_point_a_y,
  input  wire logic signed [11:0] in_point_b_x,
  input  wire logic signed [11:0] in_point_b_y,
  input  wire logic [9:0]  in_circle_radius,
  input  wire logic        in_fill_value,
  input  wire logic [6:0]  in_read_column,
  input  wire logic [3:0]  in_read_row_pair,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_glyph_code,
  output logic             out_rejected
);

  state_t state_r, state_nxt;
  logic [3:0] thick_r;
  logic       clr_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // latched command
  func_t func_r;
  logic signed [11:0] ax_r, ay_r, bx_r, by_r;
  logic [9:0] rad_r;
  logic       fillv_r;
  logic [6:0] rcol_r;
  logic [3:0] rpair_r;

  // scan bounds and position
  logic signed [15:0] x0_r, x1_r, y0_r, y1_r;
  logic [COL_W-1:0] sx_r;
  logic [ROW_W-1:0] sy_r;
  logic signed [12:0] dnum_r, dyv_r;
  logic signed [12:0] lx_r, rx_r;
  logic [19:0] r2_r;

  logic ov_r;
  logic [1:0] og_r;
  logic orj_r;
  logic top_r;
  logic [1:0] gly_r;

  // memory ports
  logic mwe;
  logic [ADDR_W-1:0] mwa, mra;
  logic mwd, mrd;

  bcbr_frame_mem u_mem (
    .clk(clk), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd)
  );

  // ---------------- setup math ----------------
  logic signed [15:0] c_x0, c_x1, c_y0, c_y1;
  logic signed [12:0] lxv, rxv, tyv, byv;
  always_comb begin
    lxv = (ax_r < bx_r) ? 13'(ax_r) : 13'(bx_r);
    rxv = (ax_r < bx_r) ? 13'(bx_r) : 13'(ax_r);
    tyv = (ay_r < by_r) ? 13'(ay_r) : 13'(by_r);
    byv = (ay_r < by_r) ? 13'(by_r) : 13'(ay_r);
    if (func_r == FUNC_CIRCLE) begin
      c_x0 = floor16(16'(ax_r) - 16'($signed({1'b0, rad_r})));
      c_x1 = ceil16(16'(ax_r) + 16'($signed({1'b0, rad_r})));
      c_y0 = floor16(16'(ay_r) - 16'($signed({1'b0, rad_r})));
      c_y1 = ceil16(16'(ay_r) + 16'($signed({1'b0, rad_r})));
    end else begin
      c_x0 = floor16(16'(lxv));
      c_x1 = ceil16(16'(rxv));
      c_y0 = floor16(16'(tyv));
      c_y1 = ceil16(16'(byv));
    end
    if (c_x0 < 16'sd0) c_x0 = 16'sd0;
    if (c_y0 < 16'sd0) c_y0 = 16'sd0;
    if (c_x1 > 16'(SCREEN_COLUMNS)) c_x1 = 16'(SCREEN_COLUMNS);
    if (c_y1 > 16'(SCREEN_ROWS)) c_y1 = 16'(SCREEN_ROWS);
  end

  logic box_empty;
  assign box_empty = (x0_r >= x1_r) || (y0_r >= y1_r);

  logic scan_last_x, scan_last_y;
  assign scan_last_x = 16'(sx_r) == x1_r - 16'sd1;
  assign scan_last_y = 16'(sy_r) == y1_r - 16'sd1;

  // ---------------- pixel test pipeline ----------------
  // stage 1: differences / products
  logic signed [14:0] px, py;
  assign px = 15'($signed({1'b0, sx_r, 4'b0}));
  assign py = 15'($signed({1'b0, sy_r, 4'b0}));

  logic        p1_v_r, p2_v_r;
  logic [ADDR_W-1:0] p1_a_r, p2_a_r;
  logic [23:0] sqx_r, sqy_r;
  logic signed [27:0] prod_r;        // dy * (px - ax)
  logic signed [27:0] ayd_r;         // ay * d
  logic signed [27:0] lyd_r, lyd2_r; // ly*d, (ly-depth)*d
  logic        inx_r;

  logic signed [14:0] cdx, cdy;
  assign cdx = 15'(ax_r) - (px + 15'sd8);
  assign cdy = 15'(ay_r) - (py + 15'sd8);

  logic signed [15:0] pmx;
  assign pmx = 16'(px) - 16'(ax_r);
  logic signed [15:0] depth16;
  assign depth16 = 16'($signed({1'b0, thick_r, 4'b0}));

  // only real pixels of a non-empty draw enter the pipeline
  logic scanning;
  assign scanning = (state_r == ST_SCAN) && (func_r != FUNC_FILL) && !box_empty &&
                    !(func_r == FUNC_BAR && ax_r == bx_r);

  always_ff @(posedge clk) begin
    sqx_r  <= 24'(cdx * cdx);
    sqy_r  <= 24'(cdy * cdy);
    prod_r <= 28'(dyv_r * pmx);
    ayd_r  <= 28'(ay_r * dnum_r);
    lyd_r  <= 28'(16'(py) * dnum_r);
    lyd2_r <= 28'((16'(py) - depth16) * dnum_r);
    inx_r  <= (16'(px) >= 16'(lx_r)) && (16'(px) <= 16'(rx_r));
    p1_a_r <= ADDR_W'(sy_r) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(sx_r);
    p2_a_r <= p1_a_r;
  end

  logic signed [28:0] numv;
  logic hit1;
  always_comb begin
    numv = 29'(ayd_r) + 29'(prod_r);
    if (func_r == FUNC_CIRCLE)
      hit1 = ({1'b0, sqx_r} + {1'b0, sqy_r}) <= 25'(r2_r);
    else
      hit1 = inx_r && (numv <= 29'(lyd_r)) && (numv >= 29'(lyd2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= scanning;
      p2_v_r <= p1_v_r && hit1;
    end
  end

  // ---------------- memory port control ----------------
  always_comb begin
    mwe = 1'b0;
    mwa = p2_a_r;
    mwd = 1'b1;
    if (clr_r) begin
      mwe = 1'b1; mwa = clr_addr_r; mwd = 1'b0;
    end else if (state_r == ST_SCAN && func_r == FUNC_FILL) begin
      mwe = 1'b1; mwa = clr_addr_r; mwd = fillv_r;
    end else if (p2_v_r) begin
      mwe = 1'b1;
    end
    mra = ADDR_W'(rpair_r) * ADDR_W'(2 * SCREEN_COLUMNS) + ADDR_W'(rcol_r);
    if (state_r == ST_READ1)
      mra = mra + ADDR_W'(SCREEN_COLUMNS);
  end

  logic top_ok, bot_ok;
  assign top_ok = (rcol_r < 7'(SCREEN_COLUMNS)) && ({rpair_r, 1'b0} < 5'(SCREEN_ROWS));
  assign bot_ok = (rcol_r < 7'(SCREEN_COLUMNS)) && ({rpair_r, 1'b1} < 5'(SCREEN_ROWS));

  // bottom pixel comes straight from the store in the first done cycle
  logic [1:0] gly_now;
  assign gly_now = {gly_r[1], top_r ? (mrd && bot_ok) : gly_r[0]};

  // ---------------- state machine ----------------
  logic fill_last;
  assign fill_last = clr_addr_r == ADDR_W'(FRAME_SIZE - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && !in_stall) state_nxt = ST_SETUP;
      ST_SETUP: begin
        if (func_r == FUNC_READ) state_nxt = ST_READ0;
        else if (func_r == FUNC_FILL) state_nxt = ST_SCAN;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (func_r == FUNC_FILL) begin
          if (fill_last) state_nxt = ST_DONE;
        end else if (box_empty || (func_r == FUNC_BAR && ax_r == bx_r)) begin
          state_nxt = ST_DONE;
        end else if (scan_last_x && scan_last_y) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ0: state_nxt = ST_READ1;
      ST_READ1: state_nxt = ST_DONE;
      ST_DONE: if (!ov_r && !p1_v_r && !p2_v_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = !(state_r == ST_IDLE) || clr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      thick_r    <= 4'd2;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      ov_r       <= 1'b0;
      og_r       <= '0;
      orj_r      <= 1'b0;
      gly_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) thick_r <= cfg_bar_thickness;
      if (clr_r) begin
        clr_addr_r <= fill_last ? '0 : clr_addr_r + 1'b1;
        if (fill_last) clr_r <= 1'b0;
      end else if (state_r == ST_SCAN && func_r == FUNC_FILL) begin
        clr_addr_r <= fill_last ? '0 : clr_addr_r + 1'b1;
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (state_r == ST_DONE && state_nxt == ST_IDLE) begin
        // hold until pipeline drained
      end
      if (state_r == ST_DONE && !ov_r && !p1_v_r && !p2_v_r) begin
        ov_r <= 1'b1;
        og_r <= (func_r == FUNC_READ) ? gly_now : 2'd0;
        orj_r <= (func_r == FUNC_BAR) && (ax_r == bx_r);
      end
      if (state_r == ST_READ1) gly_r[1] <= mrd && top_ok;
      if (state_r == ST_DONE && func_r == FUNC_READ && top_r) gly_r[0] <= mrd && bot_ok;
    end
  end

  // top_r marks the first done cycle, where bottom pixel data arrives
  always_ff @(posedge clk) begin
    top_r <= (state_r == ST_READ1);
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r  <= func_t'(in_func);
      ax_r    <= in_point_a_x;
      ay_r    <= in_point_a_y;
      bx_r    <= in_point_b_x;
      by_r    <= in_point_b_y;
      rad_r   <= in_circle_radius;
      fillv_r <= in_fill_value;
      rcol_r  <= in_read_column;
      rpair_r <= in_read_row_pair;
    end
    if (state_r == ST_SETUP) begin
      x0_r  <= c_x0;
      x1_r  <= c_x1;
      y0_r  <= c_y0;
      y1_r  <= c_y1;
      sx_r  <= COL_W'(c_x0);
      sy_r  <= ROW_W'(c_y0);
      lx_r  <= lxv;
      rx_r  <= rxv;
      r2_r  <= 20'(rad_r * rad_r);
      dnum_r <= (bx_r < ax_r) ? 13'(ax_r) - 13'(bx_r) : 13'(bx_r) - 13'(ax_r);
      dyv_r  <= (bx_r < ax_r) ? 13'(ay_r) - 13'(by_r) : 13'(by_r) - 13'(ay_r);
    end else if (scanning && func_r != FUNC_FILL) begin
      if (scan_last_x) begin
        sx_r <= COL_W'(x0_r);
        sy_r <= sy_r + 1'b1;
      end else begin
        sx_r <= sx_r + 1'b1;
      end
    end
  end

  // the glyph read must see the bottom pixel in the first done cycle: read1
  // issues the bottom address, and the registered read data is valid in done
  assign out_valid      = ov_r;
  assign out_glyph_code = og_r;
  assign out_rejected   = orj_r;

  // ---------------- assertions ----------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> in_stall) else $error("command taken during clear pass");
  a_rej_no_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> (out_glyph_code == 2'd0)) else $error("bad reject");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SETUP)) else $error("accept lost");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !clr_r) |-> !mwe) else $error("stray write");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_glyph_code) &&
                                  $stable(out_rejected))) else $error("result beat changed");

endmodule : bitmap_circle_and_bar_rasterizer
`default_nettype wire

FILE: dv/bcbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcbr_checker
// watches the command and result channels of the rasterizer, keeps a shadow
// frame, predicts each result beat and compares it field by field
// ----------------------------------------------------------------------------
module bcbr_checker
  import bcbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_bar_thickness,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [11:0] in_point_a_x,
  input  wire logic signed [11:0] in_point_a_y,
  input  wire logic signed [11:0] in_point_b_x,
  input  wire logic signed [11:0] in_point_b_y,
  input  wire logic [9:0]         in_circle_radius,
  input  wire logic               in_fill_value,
  input  wire logic [6:0]         in_read_column,
  input  wire logic [3:0]         in_read_row_pair,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         out_glyph_code,
  input  wire logic               out_rejected,
  output int                      fail_count,
  output int                      pending_count
);

  typedef struct packed {
    logic [1:0] glyph;
    logic       rej;
  } result_t;

  bit        shadow_frame [FRAME_SIZE];
  logic [3:0] shadow_thickness;
  result_t   expected_results [$];

  function automatic int fl16(int v);
    return v >= 0 ? v / 16 : -((-v + 15) / 16);
  endfunction

  function automatic bit pixel_at(int x, int y);
    if (x >= 0 && x < SCREEN_COLUMNS && y >= 0 && y < SCREEN_ROWS)
      return shadow_frame[y * SCREEN_COLUMNS + x];
    return 0;
  endfunction

  task automatic mark(int x, int y);
    if (x >= 0 && x < SCREEN_COLUMNS && y >= 0 && y < SCREEN_ROWS)
      shadow_frame[y * SCREEN_COLUMNS + x] = 1;
  endtask

  task automatic paint_circle(int cx, int cy, int r);
    int x0, x1, y0, y1;
    longint dx, dy;
    x0 = fl16(cx - r); x1 = -fl16(-(cx + r));
    y0 = fl16(cy - r); y1 = -fl16(-(cy + r));
    for (int y = 0; y < SCREEN_ROWS; y++)
      for (int x = 0; x < SCREEN_COLUMNS; x++) begin
        if (y < y0 || y >= y1 || x < x0 || x >= x1) continue;
        dx = cx - (16 * x + 8);
        dy = cy - (16 * y + 8);
        if (dx * dx + dy * dy <= longint'(r) * r) mark(x, y);
      end
  endtask

  task automatic paint_bar(int ax, int ay, int bx, int by);
    int lx, rx, ty, byy, x0, x1, y0, y1;
    longint d, dy, depth, px, num, ly;
    lx = ax < bx ? ax : bx; rx = ax < bx ? bx : ax;
    ty = ay < by ? ay : by; byy = ay < by ? by : ay;
    x0 = fl16(lx); x1 = -fl16(-rx);
    y0 = fl16(ty); y1 = -fl16(-byy);
    d = bx - ax; dy = by - ay;
    depth = 16 * shadow_thickness;
    if (d < 0) begin
      d = -d;
      dy = -dy;
    end
    for (int y = 0; y < SCREEN_ROWS; y++)
      for (int x = 0; x < SCREEN_COLUMNS; x++) begin
        if (y < y0 || y >= y1 || x < x0 || x >= x1) continue;
        px = 16 * x;
        if (px < lx || px > rx) continue;
        num = longint'(ay) * d + dy * (px - ax);
        ly = 16 * y;
        if (num <= ly * d && num >= (ly - depth) * d) mark(x, y);
      end
  endtask

  always @(posedge clk) begin
    result_t exp_r, got;
    int row;
    if (!rst_n) begin
      foreach (shadow_frame[i]) shadow_frame[i] = 0;
      shadow_thickness = 4'd2;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) shadow_thickness = cfg_bar_thickness;
      if (in_valid && !in_stall) begin
        exp_r = '0;
        case (func_t'(in_func))
          FUNC_FILL: foreach (shadow_frame[i]) shadow_frame[i] = in_fill_value;
          FUNC_CIRCLE: paint_circle(in_point_a_x, in_point_a_y, in_circle_radius);
          FUNC_BAR: begin
            if (in_point_a_x == in_point_b_x) exp_r.rej = 1;
            else paint_bar(in_point_a_x, in_point_a_y, in_point_b_x, in_point_b_y);
          end
          default: begin
            row = 2 * in_read_row_pair;
            exp_r.glyph = {pixel_at(in_read_column, row), pixel_at(in_read_column, row + 1)};
          end
        endcase
        expected_results.push_back(exp_r);
      end
      if (out_valid && !out_stall) begin
        got = '{out_glyph_code, out_rejected};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat with nothing expected: %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: glyph exp %0d got %0d, rejected exp %0d got %0d",
                       exp_r.glyph, got.glyph, exp_r.rej, got.rej);
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives draw and read commands and thickness settings into the rasterizer
// with random gaps and output stalls; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
  import bcbr_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk, rst_n;
  logic cfg_we;
  logic [3:0] cfg_bar_thickness;
  logic in_valid, in_stall;
  logic [1:0] in_func;
  logic signed [11:0] in_point_a_x, in_point_a_y, in_point_b_x, in_point_b_y;
  logic [9:0] in_circle_radius;
  logic in_fill_value;
  logic [6:0] in_read_column;
  logic [3:0] in_read_row_pair;
  logic out_valid, out_stall;
  logic [1:0] out_glyph_code;
  logic out_rejected;
  int fail_count, pending_count, idle_cycles;
  bit quiet_tail;

  bitmap_circle_and_bar_rasterizer dut (.*);
  bcbr_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // nothing accepted for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // valid stays high into the next beat unless a gap or a drain follows
  task automatic send_cmd(func_t f, int ax, int ay, int bx, int by, int r, int fv, int col,
                          int rp);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_point_a_x <= 12'(ax); in_point_a_y <= 12'(ay);
    in_point_b_x <= 12'(bx); in_point_b_y <= 12'(by);
    in_circle_radius <= 10'(r); in_fill_value <= 1'(fv);
    in_read_column <= 7'(col); in_read_row_pair <= 4'(rp);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_thickness(int t);
    drain();
    cfg_we <= 1;
    cfg_bar_thickness <= 4'(t);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // mostly on-screen coordinates, sometimes anything
  function automatic int coord(int span);
    if ($urandom_range(0, 9) == 0) return $signed(12'($urandom));
    return $urandom_range(0, span * 16 + 64) - 32;
  endfunction

  task automatic random_cmd();
    int ax, bx;
    ax = coord(SCREEN_COLUMNS);
    bx = ($urandom_range(0, 9) == 0) ? ax : coord(SCREEN_COLUMNS);
    case ($urandom_range(0, 9))
      0: send_cmd(FUNC_FILL, coord(80), coord(22), bx, coord(22), $urandom, $urandom, $urandom,
                  $urandom);
      1, 2: send_cmd(FUNC_CIRCLE, ax, coord(SCREEN_ROWS), bx, coord(22),
                     ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 120), 0, 0, 0);
      3, 4, 5: send_cmd(FUNC_BAR, ax, coord(SCREEN_ROWS), bx, coord(SCREEN_ROWS), $urandom,
                        $urandom, $urandom, $urandom);
      default: send_cmd(FUNC_READ, ax, 0, bx, 0, $urandom, $urandom,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(80, 127)
                                                    : $urandom_range(0, 79),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(11, 15)
                                                    : $urandom_range(0, 10));
    endcase
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_bar_thickness = 0; in_valid = 0; in_func = FUNC_FILL;
    in_point_a_x = 0; in_point_a_y = 0; in_point_b_x = 0; in_point_b_y = 0;
    in_circle_radius = 0; in_fill_value = 0; in_read_column = 0; in_read_row_pair = 0;
    quiet_tail = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reads after reset, circles, bars, fills, out-of-range reads
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(FUNC_CIRCLE, 640, 176, 0, 0, 80, 0, 0, 0);
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 40, 5);
    send_cmd(FUNC_CIRCLE, -2048, -2048, 0, 0, 1023, 0, 0, 0);
    send_cmd(FUNC_CIRCLE, 2047, 2047, 0, 0, 1023, 0, 0, 0);
    send_cmd(FUNC_CIRCLE, 100, 100, 0, 0, 0, 0, 0, 0);
    send_cmd(FUNC_BAR, 16, 32, 16, 200, 0, 0, 0, 0);
    send_cmd(FUNC_BAR, -2048, 2047, 2047, -2048, 0, 0, 0, 0);
    send_cmd(FUNC_BAR, 1200, 300, 50, 40, 0, 0, 0, 0);
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 79, 10);
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 127, 15);
    send_cmd(FUNC_FILL, 0, 0, 0, 0, 0, 1, 0, 0);
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 79, 10);
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 80, 11);
    send_cmd(FUNC_FILL, 0, 0, 0, 0, 0, 0, 0, 0);
    set_thickness(15);
    send_cmd(FUNC_BAR, 0, 0, 1279, 100, 0, 0, 0, 0);
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 30, 0);
    set_thickness(0);
    send_cmd(FUNC_BAR, 0, 352, 1279, 0, 0, 0, 0, 0);
    send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 30, 4);

    for (int k = 0; k < 320; k++) begin
      if (k % 64 == 63) set_thickness($urandom_range(0, 15));
      if (k == 280) quiet_tail = 1;
      random_cmd();
    end

    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
